@@ hdl/dpd_pkg.sv @@
// Shared constants and types for the binary64 divider.
package dpd_pkg;
  localparam int unsigned WordW  = 64;
  localparam int unsigned ExpW   = 11;
  localparam int unsigned FracW  = 52;
  localparam int unsigned MantW  = 53;
  localparam int unsigned RemW   = 61;
  localparam int unsigned QBits  = 105;
  localparam int unsigned NumStg = 13;
  localparam int unsigned LshW   = 7;
  localparam int unsigned PreW   = 6;
  localparam logic [ExpW-1:0] ExpMax = 11'h7FF;
  localparam logic [FracW-1:0] Quiet = 52'h8000000000000;
  localparam logic signed [13:0] Bias = 14'sd1023;

  // Operand data carried down the chain.
  typedef struct packed {
    logic             sa;
    logic             sb;
    logic [ExpW-1:0]  ea;
    logic [ExpW-1:0]  eb;
    logic [FracW-1:0] fa;
    logic [FracW-1:0] fb;
    logic [PreW-1:0]  pre;
    logic [MantW-1:0] d;
    logic [RemW-1:0]  rem;
    logic [QBits-1:0] q;
    logic             found;
    logic [LshW-1:0]  lsh;
  } work_t;
endpackage

@@ hdl/dpd_cell.sv @@
// One radix-256 restoring cell: eight quotient bits per request.
module dpd_cell #(
  parameter int unsigned Idx = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  dpd_pkg::work_t w_i,
  output logic           vld_o,
  output dpd_pkg::work_t w_o
);
  localparam logic [63:0] Low61  = 64'h1FFFFFFFFFFFFFFF;
  localparam logic [63:0] Borrow = 64'h4000000000000000;

  dpd_pkg::work_t w_d, w_q;
  logic vld_q;

  always_comb begin
    logic [63:0] r, m1, m2, t1, t2, t3;
    logic [7:0] dig;
    w_d = w_i;
    dig = '0;
    r = ({3'b0, w_i.rem} << 8) & Low61;
    for (int s = 6; s >= 0; s -= 2) begin
      m1 = {11'b0, w_i.d} << s;
      m2 = {11'b0, w_i.d} << (s + 1);
      t3 = r - (m2 + m1);
      t2 = r - m2;
      t1 = r - m1;
      if ((t3 & Borrow) == '0) begin
        dig[s+:2] = 2'd3; r = t3 & Low61;
      end else if ((t2 & Borrow) == '0) begin
        dig[s+:2] = 2'd2; r = t2 & Low61;
      end else if ((t1 & Borrow) == '0) begin
        dig[s+:2] = 2'd1; r = t1 & Low61;
      end
    end
    w_d.rem = r[dpd_pkg::RemW-1:0];
    w_d.q[8*(dpd_pkg::NumStg-Idx)+:8] = dig;
    if (!w_i.found && dig != '0) begin
      w_d.found = 1'b1;
      for (int b = 0; b < 8; b++) begin
        if (dig[b]) w_d.lsh = dpd_pkg::LshW'(8 * Idx - b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) w_q <= w_d;
  end

  assign vld_o = vld_q;
  assign w_o   = w_q;
endmodule

@@ hdl/dpd_front.sv @@
// Operand unpack, divisor normalize and first compare.
module dpd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [dpd_pkg::WordW-1:0]   a_i,
  input  logic [dpd_pkg::WordW-1:0]   b_i,
  output logic                        vld_o,
  output dpd_pkg::work_t              w_o
);
  dpd_pkg::work_t w_d, w_q;
  logic vld_q;

  always_comb begin
    logic [dpd_pkg::MantW-1:0] ma, mb, d;
    logic [dpd_pkg::PreW-1:0] pre;
    w_d.sa = a_i[63];
    w_d.sb = b_i[63];
    w_d.ea = a_i[62:52];
    w_d.eb = b_i[62:52];
    w_d.fa = a_i[51:0];
    w_d.fb = b_i[51:0];
    ma = {(w_d.ea != '0), w_d.fa};
    mb = {(w_d.eb != '0), w_d.fb};
    pre = 6'd52;
    for (int i = 0; i <= 52; i++) begin
      if (mb[i]) pre = dpd_pkg::PreW'(52 - i);
    end
    d = mb << pre;
    w_d.pre = pre;
    w_d.d = d;
    w_d.q = '0;
    w_d.lsh = '0;
    if (ma >= d) begin
      w_d.rem = dpd_pkg::RemW'(ma - d);
      w_d.q[dpd_pkg::QBits-1] = 1'b1;
      w_d.found = 1'b1;
    end else begin
      w_d.rem = dpd_pkg::RemW'(ma);
      w_d.found = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) w_q <= w_d;
  end

  assign vld_o = vld_q;
  assign w_o   = w_q;
endmodule

@@ hdl/dpd_back.sv @@
// Align, round and special-case selection; registered result.
module dpd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  dpd_pkg::work_t            w_i,
  output logic                      vld_o,
  output logic [dpd_pkg::WordW-1:0] q_o
);
  logic [dpd_pkg::WordW-1:0] q_d, q_q;
  logic vld_q;

  always_comb begin
    logic signed [13:0] ealign;
    logic [13:0] post;
    logic [dpd_pkg::QBits-1:0] al, ps;
    logic [dpd_pkg::MantW-1:0] mshort;
    logic [dpd_pkg::FracW-1:0] low52;
    logic ones, even, half, rnd, nan_res, ovf, unf;
    logic nan_a, nan_b, mz_a, mz_b, dz, zero_a, zero_b;
    logic sign;
    logic [dpd_pkg::ExpW-1:0] expo;
    logic [dpd_pkg::FracW-1:0] mant;
    logic [dpd_pkg::MantW-1:0] mb;
    ealign = $signed({3'b0, w_i.ea}) - $signed({3'b0, w_i.eb}) + dpd_pkg::Bias
             + $signed({8'b0, w_i.pre}) - $signed({7'b0, w_i.lsh})
             - ((w_i.eb == '0 && w_i.ea != '0) ? 14'sd1 : 14'sd0);
    post = '0;
    if (ealign <= 0)
      post = 14'(-ealign) + ((w_i.eb != '0 && w_i.ea != '0) ? 14'd1 : 14'd0);
    al = w_i.q << w_i.lsh;
    ps = (post >= 14'(dpd_pkg::QBits)) ? '0 : (al >> post);
    mshort = ps[104:52];
    low52 = ps[51:0];
    ones = (mshort == '1);
    even = ps[52];
    half = (low52 == dpd_pkg::Quiet);
    rnd = ps[51] & !(half & !even);
    nan_res = (ealign == 14'sd2047);
    ovf = !ealign[12] & ealign[11];
    unf = ealign[12] & ealign[11];
    zero_a = !w_i.sa && w_i.ea == '0;
    zero_b = !w_i.sb && w_i.eb == '0;
    nan_a = w_i.ea == dpd_pkg::ExpMax;
    nan_b = w_i.eb == dpd_pkg::ExpMax;
    mz_a = w_i.fa == '0;
    mz_b = w_i.fb == '0;
    mb = {(w_i.eb != '0), w_i.fb};
    dz = zero_b || mb == '0;

    priority if (nan_a && mz_a && nan_b && mz_b) sign = 1'b1;
    else if (nan_a && !mz_a) sign = w_i.sa;
    else if (nan_b && !mz_b) sign = w_i.sb;
    else if (dz && zero_a) sign = 1'b1;
    else sign = w_i.sa ^ w_i.sb;

    priority if (nan_b && !mz_b) expo = w_i.eb;
    else if ((unf || zero_a || zero_b) && !dz) expo = '0;
    else if (ovf || dz) expo = dpd_pkg::ExpMax;
    else if (nan_a) expo = w_i.ea;
    else if ((nan_b && mz_b) || ealign < 0) expo = '0;
    else expo = ealign[10:0] + {10'b0, (ones & rnd & !ovf)};

    priority if ((zero_a && zero_b) || (nan_a && mz_a && nan_b && mz_b))
      mant = dpd_pkg::Quiet;
    else if (nan_a && !mz_a) mant = w_i.fa | dpd_pkg::Quiet;
    else if (nan_b && !mz_b) mant = w_i.fb | dpd_pkg::Quiet;
    else if (ovf || nan_res || (nan_a && mz_a) || (nan_b && mz_b)) mant = '0;
    else mant = mshort[51:0] + {51'b0, rnd};

    q_d = {sign, expo, mant};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) q_q <= q_d;
  end

  assign vld_o = vld_q;
  assign q_o   = q_q;
endmodule

@@ hdl/double_precision_divide_top.sv @@
// Top level of the pipelined binary64 divider.
//  channel | direction | signals
//  in      | request   | in_valid_i, in_stall_o, dividend_i, divisor_i
//  out     | result    | out_valid_o, out_stall_i, quotient_o
// One request per cycle while the chain is not held; a request passes through the
// front stage, 13 radix-256 cells and the result register. The whole chain
// holds while the output is stalled and full; bubbles inside the chain are not
// squeezed out. Reset clears the valid bits only.
module double_precision_divide_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [dpd_pkg::WordW-1:0] dividend_i,
  input  logic [dpd_pkg::WordW-1:0] divisor_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [dpd_pkg::WordW-1:0] quotient_o
);
  localparam int unsigned N = dpd_pkg::NumStg;
  logic en;
  logic [N:0] vld;
  dpd_pkg::work_t w [N+1];

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  dpd_front u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i),
    .a_i(dividend_i), .b_i(divisor_i), .vld_o(vld[0]), .w_o(w[0])
  );

  for (genvar k = 1; k <= N; k++) begin : g_cell
    dpd_cell #(.Idx(k)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .vld_i(vld[k-1]), .w_i(w[k-1]),
      .vld_o(vld[k]), .w_o(w[k])
    );
  end

  dpd_back u_back (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld[N]), .w_i(w[N]),
    .vld_o(out_valid_o), .q_o(quotient_o)
  );
endmodule

@@ hdl/dpd_checker.sv @@
// Port-level checker for the divider, bound to the top level.
module dpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] quotient_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(quotient_o))
    else $error("stalled result changed");
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without full output");
  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("valid during reset");
endmodule

bind double_precision_divide_top dpd_checker u_dpd_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .quotient_o
);
